@@ hdl/mtc_pkg.sv @@
package mtc_pkg;

  localparam int unsigned MAX_ID_LEN_DEF = 29;
  localparam int unsigned MAX_TERMS_DEF  = 3;

  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // term flag bits
  localparam int unsigned F_NOT    = 0;
  localparam int unsigned F_BEFORE = 1;
  localparam int unsigned F_AFTER  = 2;

  typedef enum logic [2:0] {
    M_IDLE,
    M_EXPECT,
    M_NOT,
    M_STAR,
    M_IN_ID,
    M_AFTER,
    M_DEAD
  } mode_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_AND,
    OP_OR
  } op_e;

  // shift controls shared by every cell of the chain
  typedef struct packed {
    logic win_shift;
    logic raw_shift;
    logic plain_load;
  } cell_ctl_t;

  function automatic logic is_id_char(input logic [7:0] c);
    return (c == CH_UNDER) || (c == CH_COLON) ||
           (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    return (c == CH_BANG) || (c == CH_STAR) || (c == CH_AMP) || (c == CH_BAR);
  endfunction

endpackage

@@ hdl/mtc_cell.sv @@
module mtc_cell #(
  parameter int unsigned NUM_TERMS = mtc_pkg::MAX_TERMS_DEF
) (
  input  logic                  clk_i,
  input  mtc_pkg::cell_ctl_t    ctl_i,
  input  logic [NUM_TERMS-1:0]  app_en_i,
  input  logic [7:0]            win_prev_i,
  input  logic [7:0]            raw_prev_i,
  input  logic [7:0]            term_prev_i [NUM_TERMS],
  output logic [7:0]            win_o,
  output logic [7:0]            raw_o,
  output logic [7:0]            term_o [NUM_TERMS],
  output logic [NUM_TERMS-1:0]  eq_o
);

  logic [7:0] win_q, win_d;
  logic [7:0] raw_q, raw_d;
  logic [7:0] term_q [NUM_TERMS];
  logic [7:0] term_d [NUM_TERMS];

  assign win_d = ctl_i.win_shift ? win_prev_i : win_q;
  assign raw_d = ctl_i.raw_shift ? raw_prev_i : raw_q;

  always_comb begin
    for (int t = 0; t < NUM_TERMS; t++) begin
      if (t == 0 && ctl_i.plain_load) begin
        term_d[t] = raw_d;
      end else if (app_en_i[t]) begin
        term_d[t] = term_prev_i[t];
      end else begin
        term_d[t] = term_q[t];
      end
      // compare against the window as it stands after this beat
      eq_o[t] = (term_q[t] == win_d);
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    raw_q <= raw_d;
    for (int t = 0; t < NUM_TERMS; t++) begin
      term_q[t] <= term_d[t];
    end
  end

  assign win_o  = win_q;
  assign raw_o  = raw_q;
  assign term_o = term_q;

endmodule

@@ hdl/wildcard_name_query_matcher_top.sv @@
// Wildcard name matcher. A beat with tuser 0 carries a query byte, tuser 1 a name byte;
// tlast closes the string and produces one result beat. A query is up to MAX_TERMS terms
// of the form [!][*]id[*] joined by & or | (spaces ignored, missing operator is and,
// evaluation strictly left to right); a line with none of ! * & | is one exact term.
// Names are tested against all terms at once by a chain of MAX_ID_LEN cells, each holding
// one character of the name window, of the raw query line and of every term (stored in
// reverse so appends and name bytes are both plain shifts). One beat is taken every clock
// cycle while the input is not stalled; a result appears in the cycle after its closing
// beat and is held in an output register; input stalls only while that result waits and
// the sink holds it off. No clearing pass after reset.
module wildcard_name_query_matcher_top #(
  parameter int unsigned MAX_ID_LEN = mtc_pkg::MAX_ID_LEN_DEF,
  parameter int unsigned MAX_TERMS  = mtc_pkg::MAX_TERMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] data_byte, [8] no_byte, rest zero
  input  logic        s_axis_tuser_i,   // kind
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [0] matched, [1] query_bad, [3:2] terms_found
  output logic        m_axis_tuser_o    // result_kind
);

  localparam int unsigned LW  = $clog2(MAX_ID_LEN + 1);
  localparam int unsigned NW  = $clog2(MAX_ID_LEN + 2);
  localparam int unsigned CW  = $clog2(MAX_TERMS + 1);
  localparam int unsigned TIW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CIW = (MAX_ID_LEN > 1) ? $clog2(MAX_ID_LEN) : 1;

  // input beat
  logic       in_acc, kind, none, last;
  logic [7:0] c;
  logic       name_chr;

  assign in_acc   = s_axis_tvalid_i & s_axis_tready_o;
  assign kind     = s_axis_tuser_i;
  assign c        = s_axis_tdata_i[7:0];
  assign none     = s_axis_tdata_i[8];
  assign last     = s_axis_tlast_i;
  assign name_chr = in_acc & kind & ~none;

  // query and name state
  mtc_pkg::mode_e mode_q, mode_d;
  mtc_pkg::op_e   op_q [MAX_TERMS];
  mtc_pkg::op_e   op_d [MAX_TERMS];
  logic [LW-1:0]  len_q [MAX_TERMS];
  logic [LW-1:0]  len_d [MAX_TERMS];
  logic [2:0]     flg_q [MAX_TERMS];
  logic [2:0]     flg_d [MAX_TERMS];
  logic [CW-1:0]  cnt_q, cnt_d, cur;
  logic [NW-1:0]  rawlen_q, rawlen_d;
  logic           spec_q, spec_d, err_q, err_d;
  logic [NW-1:0]  nlen_q, nlen_d, nlen_nx;
  logic [MAX_TERMS-1:0] pal_q, pal_d, cs_q, cs_d;

  // output register
  logic       out_vld_q;
  logic       out_kind_q, out_match_q, out_bad_q;
  logic [1:0] out_terms_q;
  logic       load_out, res_match;

  // chain wiring
  mtc_pkg::cell_ctl_t   cell_ctl;
  logic                 raw_shift, plain_load, clr_name, ok, acc, tm;
  logic [MAX_TERMS-1:0] app_en, tail;
  logic [7:0]           win_chain  [MAX_ID_LEN];
  logic [7:0]           raw_chain  [MAX_ID_LEN];
  logic [7:0]           term_chain [MAX_ID_LEN][MAX_TERMS];
  logic [MAX_TERMS-1:0] eq_all     [MAX_ID_LEN];
  logic [7:0]           rsel [MAX_TERMS];
  logic [NW-1:0]        ridx [MAX_TERMS];

  assign cell_ctl = '{win_shift: name_chr, raw_shift: raw_shift, plain_load: plain_load};

  for (genvar i = 0; i < MAX_ID_LEN; i++) begin : g_cell
    logic [7:0] win_p, raw_p;
    logic [7:0] term_p [MAX_TERMS];
    if (i == 0) begin : g_head
      assign win_p = c;
      assign raw_p = c;
      for (genvar t = 0; t < MAX_TERMS; t++) begin : g_t
        assign term_p[t] = c;
      end
    end else begin : g_body
      assign win_p = win_chain[i-1];
      assign raw_p = raw_chain[i-1];
      for (genvar t = 0; t < MAX_TERMS; t++) begin : g_t
        assign term_p[t] = term_chain[i-1][t];
      end
    end
    mtc_cell #(.NUM_TERMS(MAX_TERMS)) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl),
      .app_en_i    (app_en),
      .win_prev_i  (win_p),
      .raw_prev_i  (raw_p),
      .term_prev_i (term_p),
      .win_o       (win_chain[i]),
      .raw_o       (raw_chain[i]),
      .term_o      (term_chain[i]),
      .eq_o        (eq_all[i])
    );
  end

  // name length after this beat, saturating one past the longest term
  assign nlen_nx = (name_chr && nlen_q < NW'(MAX_ID_LEN + 1)) ? nlen_q + NW'(1) : nlen_q;

  // suffix test of every term against the updated window, plus the term
  // character at the current name position for the prefix test
  always_comb begin
    for (int t = 0; t < MAX_TERMS; t++) begin
      tail[t] = (nlen_nx >= NW'(len_q[t]));
      for (int i = 0; i < MAX_ID_LEN; i++) begin
        if (LW'(i) < len_q[t] && !eq_all[i][t]) begin
          tail[t] = 1'b0;
        end
      end
      // terms are held reversed: character p sits in cell len-1-p
      ridx[t] = NW'(len_q[t]) - NW'(1) - nlen_q;
      rsel[t] = term_chain[ridx[t][CIW-1:0]][t];
    end
  end

  always_comb begin
    mode_d     = mode_q;
    op_d       = op_q;
    len_d      = len_q;
    flg_d      = flg_q;
    cnt_d      = cnt_q;
    rawlen_d   = rawlen_q;
    spec_d     = spec_q;
    err_d      = err_q;
    nlen_d     = nlen_q;
    pal_d      = pal_q;
    cs_d       = cs_q;
    raw_shift  = 1'b0;
    plain_load = 1'b0;
    app_en     = '0;
    clr_name   = 1'b0;
    load_out   = 1'b0;
    res_match  = 1'b0;
    cur        = '0;
    ok         = 1'b0;
    acc        = 1'b1;
    tm         = 1'b0;

    if (in_acc && !kind) begin
      // first query beat after a finished query starts over
      if (mode_q == mtc_pkg::M_IDLE) begin
        for (int t = 0; t < MAX_TERMS; t++) begin
          len_d[t] = '0;
          flg_d[t] = '0;
          op_d[t]  = mtc_pkg::OP_NONE;
        end
        cnt_d    = '0;
        rawlen_d = '0;
        spec_d   = 1'b0;
        err_d    = 1'b0;
        mode_d   = mtc_pkg::M_EXPECT;
        clr_name = 1'b1;
      end
      if (!none) begin
        if (rawlen_d < NW'(MAX_ID_LEN)) begin
          raw_shift = 1'b1;
        end
        if (rawlen_d < NW'(MAX_ID_LEN + 1)) begin
          rawlen_d = rawlen_d + NW'(1);
        end
        if (mtc_pkg::is_special(c)) begin
          spec_d = 1'b1;
        end
        cur = cnt_d - CW'(1);
        if (mode_d != mtc_pkg::M_DEAD) begin
          if (mtc_pkg::is_id_char(c)) begin
            ok = 1'b1;
            if (mode_d inside {mtc_pkg::M_EXPECT, mtc_pkg::M_AFTER}) begin
              if (cnt_d >= CW'(MAX_TERMS)) begin
                ok     = 1'b0;
                err_d  = 1'b1;
                mode_d = mtc_pkg::M_DEAD;
              end else begin
                len_d[cnt_d[TIW-1:0]] = '0;
                flg_d[cnt_d[TIW-1:0]] = '0;
                cnt_d = cnt_d + CW'(1);
              end
            end
            if (ok) begin
              cur = cnt_d - CW'(1);
              if (cnt_d == '0 || len_d[cur[TIW-1:0]] >= LW'(MAX_ID_LEN)) begin
                err_d  = 1'b1;
                mode_d = mtc_pkg::M_DEAD;
              end else begin
                app_en[cur[TIW-1:0]] = 1'b1;
                len_d[cur[TIW-1:0]]  = len_d[cur[TIW-1:0]] + LW'(1);
                mode_d = mtc_pkg::M_IN_ID;
              end
            end
          end else if (c == mtc_pkg::CH_BANG) begin
            if (mode_d inside {mtc_pkg::M_EXPECT, mtc_pkg::M_AFTER} &&
                cnt_d < CW'(MAX_TERMS)) begin
              len_d[cnt_d[TIW-1:0]] = '0;
              flg_d[cnt_d[TIW-1:0]] = 3'b001 << mtc_pkg::F_NOT;
              cnt_d  = cnt_d + CW'(1);
              mode_d = mtc_pkg::M_NOT;
            end else begin
              err_d  = 1'b1;
              mode_d = mtc_pkg::M_DEAD;
            end
          end else if (c == mtc_pkg::CH_STAR) begin
            if (mode_d inside {mtc_pkg::M_EXPECT, mtc_pkg::M_AFTER}) begin
              if (cnt_d < CW'(MAX_TERMS)) begin
                len_d[cnt_d[TIW-1:0]] = '0;
                flg_d[cnt_d[TIW-1:0]] = 3'b001 << mtc_pkg::F_BEFORE;
                cnt_d  = cnt_d + CW'(1);
                mode_d = mtc_pkg::M_STAR;
              end else begin
                err_d  = 1'b1;
                mode_d = mtc_pkg::M_DEAD;
              end
            end else if (mode_d == mtc_pkg::M_NOT) begin
              flg_d[cur[TIW-1:0]][mtc_pkg::F_BEFORE] = 1'b1;
              mode_d = mtc_pkg::M_STAR;
            end else if (mode_d == mtc_pkg::M_IN_ID) begin
              flg_d[cur[TIW-1:0]][mtc_pkg::F_AFTER] = 1'b1;
              mode_d = mtc_pkg::M_AFTER;
            end else begin
              err_d  = 1'b1;
              mode_d = mtc_pkg::M_DEAD;
            end
          end else if (c == mtc_pkg::CH_AMP || c == mtc_pkg::CH_BAR) begin
            if (mode_d inside {mtc_pkg::M_IN_ID, mtc_pkg::M_AFTER} &&
                cnt_d < CW'(MAX_TERMS)) begin
              op_d[cnt_d[TIW-1:0]] = (c == mtc_pkg::CH_AMP) ? mtc_pkg::OP_AND
                                                            : mtc_pkg::OP_OR;
              mode_d = mtc_pkg::M_EXPECT;
            end else begin
              err_d  = 1'b1;
              mode_d = mtc_pkg::M_DEAD;
            end
          end else if (c == mtc_pkg::CH_SPACE) begin
            if (mode_d == mtc_pkg::M_IN_ID) begin
              mode_d = mtc_pkg::M_AFTER;
            end
          end else begin
            err_d  = 1'b1;
            mode_d = mtc_pkg::M_DEAD;
          end
        end
      end
      if (last) begin
        if (!spec_d) begin
          // plain line: the whole raw line becomes one exact term
          for (int t = 0; t < MAX_TERMS; t++) begin
            flg_d[t] = '0;
            op_d[t]  = mtc_pkg::OP_NONE;
          end
          plain_load = 1'b1;
          len_d[0] = (rawlen_d > NW'(MAX_ID_LEN)) ? LW'(MAX_ID_LEN) : rawlen_d[LW-1:0];
          cnt_d    = CW'(1);
          err_d    = (rawlen_d > NW'(MAX_ID_LEN));
        end else if (mode_d inside {mtc_pkg::M_NOT, mtc_pkg::M_STAR, mtc_pkg::M_EXPECT}) begin
          // dangling modifier or operator
          err_d = 1'b1;
        end
        mode_d   = mtc_pkg::M_IDLE;
        clr_name = 1'b1;
        load_out = 1'b1;
      end
    end else if (in_acc && kind) begin
      if (!none) begin
        for (int t = 0; t < MAX_TERMS; t++) begin
          if (CW'(t) < cnt_q) begin
            if (nlen_q < NW'(len_q[t]) && rsel[t] != c) begin
              pal_d[t] = 1'b0;
            end
            if (tail[t]) begin
              cs_d[t] = 1'b1;
            end
          end
        end
        nlen_d = nlen_nx;
      end
      if (last) begin
        for (int t = 0; t < MAX_TERMS; t++) begin
          if (CW'(t) < cnt_q) begin
            if (flg_q[t][mtc_pkg::F_BEFORE] && flg_q[t][mtc_pkg::F_AFTER]) begin
              tm = (len_q[t] == '0) || cs_d[t];
            end else if (flg_q[t][mtc_pkg::F_AFTER]) begin
              tm = pal_d[t] && (nlen_d >= NW'(len_q[t]));
            end else if (flg_q[t][mtc_pkg::F_BEFORE]) begin
              tm = tail[t];
            end else begin
              tm = pal_d[t] && (nlen_d == NW'(len_q[t]));
            end
            tm = tm ^ flg_q[t][mtc_pkg::F_NOT];
            if (t > 0 && op_q[t] == mtc_pkg::OP_OR) begin
              acc = acc | tm;
            end else begin
              acc = acc & tm;
            end
          end
        end
        res_match = acc & ~err_q;
        clr_name  = 1'b1;
        load_out  = 1'b1;
      end
    end

    if (clr_name) begin
      nlen_d = '0;
      pal_d  = '1;
      cs_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mtc_pkg::M_IDLE;
      cnt_q    <= '0;
      rawlen_q <= '0;
      spec_q   <= 1'b0;
      err_q    <= 1'b0;
      nlen_q   <= '0;
      pal_q    <= '1;
      cs_q     <= '0;
      for (int t = 0; t < MAX_TERMS; t++) begin
        len_q[t] <= '0;
        flg_q[t] <= '0;
        op_q[t]  <= mtc_pkg::OP_NONE;
      end
      out_vld_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      rawlen_q <= rawlen_d;
      spec_q   <= spec_d;
      err_q    <= err_d;
      nlen_q   <= nlen_d;
      pal_q    <= pal_d;
      cs_q     <= cs_d;
      len_q    <= len_d;
      flg_q    <= flg_d;
      op_q     <= op_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_kind_q  <= kind;
      out_match_q <= res_match;
      out_bad_q   <= err_d;
      out_terms_q <= 2'(cnt_d);
    end
  end

  // input stalls only while a result waits and the sink holds it
  assign s_axis_tready_o = ~out_vld_q | m_axis_tready_i;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {4'b0000, out_terms_q, out_bad_q, out_match_q};

endmodule

@@ hdl/mtc_checker.sv @@
module mtc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [15:0] s_axis_tdata_i,
  input logic        s_axis_tuser_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // a pending result is held until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // input is never blocked while the output side is empty
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // query results never report a match
  a_qmatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> !m_axis_tdata_o[0])
    else $error("query result with match set");

  // a bad query matches no name
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1] |-> !m_axis_tdata_o[0])
    else $error("match reported under bad query");

  // a beat without last creates no result
  a_nolast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tlast_i &&
    !(m_axis_tvalid_o && !m_axis_tready_i) |=> !m_axis_tvalid_o)
    else $error("result without closing beat");

endmodule

bind wildcard_name_query_matcher_top mtc_checker u_mtc_checker (.*);

@@ test/wildcard_name_query_matcher_checker.sv @@
`timescale 1ns / 100ps

module wildcard_name_query_matcher_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] data_byte, [8] no_byte
  input  logic        s_axis_tuser_i,   // kind
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // [0] matched, [1] query_bad, [3:2] terms_found
  input  logic        m_axis_tuser_i,   // result_kind
  output int          errors_o,
  output int          pending_o
);

  localparam int IDL = mtc_pkg::MAX_ID_LEN_DEF;
  localparam int NT  = mtc_pkg::MAX_TERMS_DEF;

  typedef struct packed {
    logic       kind;
    logic       matched;
    logic       bad;
    logic [1:0] terms;
  } verdict_t;

  verdict_t verdict_q[$];

  logic [7:0]     tch[NT][IDL];
  int             tlen[NT];
  logic [2:0]     tflg[NT];
  mtc_pkg::op_e   tjoin[NT];
  int             tcnt;
  mtc_pkg::mode_e mode;
  logic [7:0]     line[IDL];
  int             line_len;
  logic           special;
  logic           bad;
  logic [7:0]     win[IDL];
  int             nlen;
  logic           pre_ok[NT];
  logic           seen_in[NT];

  function automatic void clear_name();
    for (int i = 0; i < IDL; i++) win[i] = 8'h00;
    nlen = 0;
    for (int t = 0; t < NT; t++) begin
      pre_ok[t] = 1'b1;
      seen_in[t] = 1'b0;
    end
  endfunction

  function automatic void begin_query();
    for (int t = 0; t < NT; t++) begin
      tlen[t] = 0;
      tflg[t] = '0;
      tjoin[t] = mtc_pkg::OP_NONE;
    end
    tcnt = 0;
    line_len = 0;
    special = 1'b0;
    bad = 1'b0;
    mode = mtc_pkg::M_EXPECT;
    clear_name();
  endfunction

  function automatic void abort_parse();
    bad = 1'b1;
    mode = mtc_pkg::M_DEAD;
  endfunction

  function automatic logic new_term();
    if (tcnt >= NT) begin
      abort_parse();
      return 1'b0;
    end
    tlen[tcnt] = 0;
    tflg[tcnt] = '0;
    tcnt++;
    return 1'b1;
  endfunction

  function automatic void add_id_char(logic [7:0] c);
    int t;
    t = tcnt - 1;
    if (tcnt == 0 || tlen[t] >= IDL) begin
      abort_parse();
      return;
    end
    tch[t][tlen[t]] = c;
    tlen[t]++;
    mode = mtc_pkg::M_IN_ID;
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    mtc_pkg::mode_e m;
    int             cur;
    m = mode;
    cur = tcnt - 1;
    if (m == mtc_pkg::M_DEAD) return;
    if (mtc_pkg::is_id_char(c)) begin
      if ((m == mtc_pkg::M_EXPECT || m == mtc_pkg::M_AFTER) && !new_term()) return;
      add_id_char(c);
    end else if (c == mtc_pkg::CH_BANG) begin
      if ((m == mtc_pkg::M_EXPECT || m == mtc_pkg::M_AFTER) && new_term()) begin
        tflg[tcnt-1][mtc_pkg::F_NOT] = 1'b1;
        mode = mtc_pkg::M_NOT;
      end else if (mode != mtc_pkg::M_DEAD) begin
        abort_parse();
      end
    end else if (c == mtc_pkg::CH_STAR) begin
      if (m == mtc_pkg::M_EXPECT || m == mtc_pkg::M_AFTER) begin
        if (new_term()) begin
          tflg[tcnt-1][mtc_pkg::F_BEFORE] = 1'b1;
          mode = mtc_pkg::M_STAR;
        end
      end else if (m == mtc_pkg::M_NOT && cur >= 0) begin
        tflg[cur][mtc_pkg::F_BEFORE] = 1'b1;
        mode = mtc_pkg::M_STAR;
      end else if (m == mtc_pkg::M_IN_ID && cur >= 0) begin
        tflg[cur][mtc_pkg::F_AFTER] = 1'b1;
        mode = mtc_pkg::M_AFTER;
      end else begin
        abort_parse();
      end
    end else if (c == mtc_pkg::CH_AMP || c == mtc_pkg::CH_BAR) begin
      if ((m == mtc_pkg::M_IN_ID || m == mtc_pkg::M_AFTER) && tcnt < NT) begin
        tjoin[tcnt] = (c == mtc_pkg::CH_AMP) ? mtc_pkg::OP_AND : mtc_pkg::OP_OR;
        mode = mtc_pkg::M_EXPECT;
      end else begin
        abort_parse();
      end
    end else if (c == mtc_pkg::CH_SPACE) begin
      if (m == mtc_pkg::M_IN_ID) mode = mtc_pkg::M_AFTER;
    end else begin
      abort_parse();
    end
  endfunction

  function automatic void close_query();
    if (!special) begin
      for (int t = 0; t < NT; t++) begin
        tflg[t] = '0;
        tjoin[t] = mtc_pkg::OP_NONE;
      end
      for (int i = 0; i < IDL; i++) if (i < line_len) tch[0][i] = line[i];
      tlen[0] = (line_len > IDL) ? IDL : line_len;
      tcnt = 1;
      bad = line_len > IDL;
    end else if (mode == mtc_pkg::M_NOT || mode == mtc_pkg::M_STAR ||
                 mode == mtc_pkg::M_EXPECT) begin
      bad = 1'b1;
    end
    mode = mtc_pkg::M_IDLE;
    clear_name();
  endfunction

  function automatic logic tail_hit(int t);
    if (nlen < tlen[t]) return 1'b0;
    for (int i = 0; i < tlen[t]; i++)
      if (tch[t][tlen[t]-1-i] != win[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void shift_name(logic [7:0] c);
    for (int t = 0; t < tcnt; t++)
      if (nlen < tlen[t] && tch[t][nlen] != c) pre_ok[t] = 1'b0;
    for (int i = IDL - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = c;
    if (nlen < IDL + 1) nlen++;
    for (int t = 0; t < tcnt; t++) if (tail_hit(t)) seen_in[t] = 1'b1;
  endfunction

  function automatic logic term_hit(int t);
    logic m;
    if (tflg[t][mtc_pkg::F_BEFORE] && tflg[t][mtc_pkg::F_AFTER])
      m = (tlen[t] == 0) || seen_in[t];
    else if (tflg[t][mtc_pkg::F_AFTER]) m = pre_ok[t] && nlen >= tlen[t];
    else if (tflg[t][mtc_pkg::F_BEFORE]) m = tail_hit(t);
    else m = pre_ok[t] && nlen == tlen[t];
    return tflg[t][mtc_pkg::F_NOT] ? !m : m;
  endfunction

  function automatic logic name_verdict();
    logic acc;
    logic m;
    acc = 1'b1;
    if (bad) return 1'b0;
    for (int t = 0; t < tcnt; t++) begin
      m = term_hit(t);
      if (t > 0 && tjoin[t] == mtc_pkg::OP_OR) acc = acc || m;
      else acc = acc && m;
    end
    return acc;
  endfunction

  function automatic void take_beat(logic kind, logic [7:0] c, logic none, logic last);
    verdict_t v;
    v.matched = 1'b0;
    if (!kind) begin
      if (mode == mtc_pkg::M_IDLE) begin_query();
      if (!none) begin
        if (line_len < IDL) line[line_len] = c;
        if (line_len < IDL + 1) line_len++;
        if (mtc_pkg::is_special(c)) special = 1'b1;
        parse_byte(c);
      end
      if (!last) return;
      close_query();
    end else begin
      if (!none) shift_name(c);
      if (!last) return;
      v.matched = name_verdict();
      clear_name();
    end
    v.kind = kind;
    v.bad = bad;
    v.terms = tcnt[1:0];
    verdict_q.push_back(v);
  endfunction

  assign pending_o = verdict_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t got;
    verdict_t want;
    if (!rst_ni) begin
      verdict_q.delete();
      errors_o <= 0;
      begin_query();
      mode = mtc_pkg::M_IDLE;
    end else begin
      // results first: a beat accepted this edge cannot yield its result yet
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = {m_axis_tuser_i, m_axis_tdata_i[0], m_axis_tdata_i[1], m_axis_tdata_i[3:2]};
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result beat %b", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch kind/matched/bad/terms expected %b actual %b",
                     $time, want, got);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        take_beat(s_axis_tuser_i, s_axis_tdata_i[7:0], s_axis_tdata_i[8], s_axis_tlast_i);
    end
  end

endmodule

@@ test/wildcard_name_query_matcher_top_test.sv @@
`timescale 1ns / 100ps

module wildcard_name_query_matcher_top_test;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [15:0] s_data = '0;   // [7:0] data_byte, [8] no_byte
  logic        s_user = 1'b0; // kind
  logic        s_last = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_data;        // [0] matched, [1] query_bad, [3:2] terms_found
  logic        m_user;        // result_kind
  int          errors;
  int          pending;
  int          idle_cycles;
  int          beats = 0;     // input beats accepted so far
  logic        calm;          // no idling in the last part of the run

  // pool of characters that exercise the parser and the comparisons
  localparam int POOL_N = 14;
  logic [7:0] pool[POOL_N] = '{8'h61, 8'h62, 8'h63, 8'h3A, 8'h5F, 8'h30, 8'h5A,
                               mtc_pkg::CH_BANG, mtc_pkg::CH_STAR, mtc_pkg::CH_AMP,
                               mtc_pkg::CH_BAR, mtc_pkg::CH_SPACE, 8'h2E, 8'hFF};

  always #5 clk_i = ~clk_i;

  wildcard_name_query_matcher_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  wildcard_name_query_matcher_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_i(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_i(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_i (m_data),
    .m_axis_tuser_i (m_user),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // receiver: stalls in random bursts until the calm phase
  always @(posedge clk_i) begin
    int burst;
    if (!calm && $urandom_range(0, 7) == 0) begin
      burst = $urandom_range(1, 11);
      m_ready <= 1'b0;
      repeat (burst) @(posedge clk_i);
    end
    m_ready <= 1'b1;
  end

  // watchdog on cycles with no accepted beat on either side
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("wildcard_name_query_matcher_top_test: done, errors");
      $finish;
    end
  end

  // one beat; valid stays high into the next beat unless a gap is drawn
  task automatic send_beat(logic kind, logic [7:0] c, logic none, logic last);
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {7'd0, none, c};
    s_last  <= last;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    beats++;
  endtask

  task automatic send_text(logic kind, string s);
    if (s.len() == 0) send_beat(kind, 8'h00, 1'b1, 1'b1);
    for (int i = 0; i < s.len(); i++) send_beat(kind, s[i], 1'b0, i == s.len() - 1);
  endtask

  function automatic string rand_id(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(pool[$urandom_range(0, 6)])};
    return s;
  endfunction

  // well-formed query with random terms and modifiers
  function automatic string rand_query();
    string q;
    int    n;
    n = $urandom_range(1, 3);
    q = "";
    for (int t = 0; t < n; t++) begin
      if (t > 0) q = {q, ($urandom_range(0, 1) ? "&" : "|")};
      if ($urandom_range(0, 2) == 0) q = {q, " "};
      if ($urandom_range(0, 2) == 0) q = {q, "!"};
      if ($urandom_range(0, 1)) q = {q, "*"};
      q = {q, rand_id($urandom_range(1, 3))};
      if ($urandom_range(0, 1)) q = {q, "*"};
    end
    return q;
  endfunction

  task automatic send_noise(logic kind, int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom) : pool[$urandom_range(0, POOL_N - 1)];
      send_beat(kind, c, $urandom_range(0, 15) == 0, i == n - 1);
    end
  endtask

  initial begin
    int guard;
    calm = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, operators, error cases
    send_text(1, "abc");                          // empty query matches all
    send_text(0, "ab c");                          // plain line, spaces kept
    send_text(1, "ab c");
    send_text(0, "ab*&!*c:_*|Z9");
    send_text(1, "ab");
    send_text(0, "abcdefghijklmnopqrstuvwxyz0123");  // plain line too long
    send_text(1, "abc");
    send_text(0, "!!a");                           // doubled not
    send_text(0, "a&b&c&d");                       // extra term
    send_text(0, "a&");                            // dangling operator
    send_text(0, "a!");
    send_text(0, "*abcdefghijklmnopqrstuvwxyz0123*"); // identifier too long
    send_text(0, "*");
    send_text(0, "");
    send_text(1, "");
    send_beat(0, 8'hFF, 1'b0, 1'b0);               // any other byte
    send_beat(0, 8'h00, 1'b1, 1'b1);
    send_text(0, "*cd*");
    send_text(1, "abcdefghijklmnopqrstuvwxyz0123456789");  // long name
    send_text(0, "a");
    send_text(1, "ab");
    send_text(0, "x*");                           // query after a closed name
    send_beat(1, "q", 1'b0, 1'b1);

    // hold off until every expectation is met
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    while (beats < 1750) begin
      if (beats > 1550) calm = 1'b1;
      case ($urandom_range(0, 9))
        0: send_noise(0, $urandom_range(1, 12));
        1: send_noise(1, $urandom_range(1, 12));
        2, 3: send_text(0, rand_query());
        default: send_text(1, rand_id($urandom_range(0, 8)));
      endcase
    end
    s_valid <= 1'b0;

    guard = 0;
    @(posedge clk_i);
    while (pending != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("wildcard_name_query_matcher_top_test: done, clean");
    end else begin
      $display("wildcard_name_query_matcher_top_test: done, errors");
    end
    $finish;
  end

endmodule

@@ wildcard_name_query_matcher_top.f @@
hdl/mtc_pkg.sv
hdl/mtc_cell.sv
hdl/wildcard_name_query_matcher_top.sv
hdl/mtc_checker.sv
test/wildcard_name_query_matcher_checker.sv
test/wildcard_name_query_matcher_top_test.sv
